[hdl/poly1305_mac_accumulator_unit_macros.svh]
// assertion helpers for the poly1305 accumulator
`ifndef POLY1305_MAC_ACCUMULATOR_UNIT_MACROS_SVH
`define POLY1305_MAC_ACCUMULATOR_UNIT_MACROS_SVH

// property holds on every clock edge outside reset
`define P1305_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// property checked from reset on
`define P1305_ASSERT_RST(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

[hdl/p1305_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package p1305_pkg;

   localparam int unsigned AccWidth  = 130;
   localparam int unsigned KeyWidth  = 128;
   localparam int unsigned LimbWidth = 26;
   localparam int unsigned NumLimbs  = 5;
   localparam int unsigned CsrIdxWidth = 2;

   localparam logic [CsrIdxWidth-1:0] CSR_R_LOW  = 2'd0;
   localparam logic [CsrIdxWidth-1:0] CSR_R_HIGH = 2'd1;
   localparam logic [CsrIdxWidth-1:0] CSR_S_LOW  = 2'd2;
   localparam logic [CsrIdxWidth-1:0] CSR_S_HIGH = 2'd3;

   localparam logic [127:0] R_CLAMP_MASK = 128'h0FFFFFFC_0FFFFFFC_0FFFFFFC_0FFFFFFF;

   typedef struct packed {
      logic        last_block;
      logic [4:0]  block_bytes;
      logic [63:0] block_high;
      logic [63:0] block_low;
   } req_payload_type;

   typedef struct packed {
      logic [63:0] tag_high;
      logic [63:0] tag_low;
   } rsp_payload_type;

   // controller to datapath
   typedef struct packed {
      logic       load;       // capture block and add it into the accumulator
      logic       clear_prod; // start a new product
      logic       mac;        // one partial product step
      logic [2:0] limb;       // 32-bit word of h used in this step
      logic [1:0] rword;      // 32-bit word of r used in this step
      logic       reduce;     // fold the product modulo 2^130-5
      logic       finish;     // final subtraction and write back
      logic       tag;        // form tag and clear accumulator
   } dp_cmd_type;

endpackage
`default_nettype wire

[hdl/p1305_datapath.sv]
`timescale 1ns / 1ps
`default_nettype none
module p1305_datapath
   import p1305_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire dp_cmd_type      cmd,
   input  wire req_payload_type req_data,
   input  wire logic [127:0]    key_r,
   input  wire logic [127:0]    key_s,
   output rsp_payload_type      tag_out
);

   // h: accumulator plus block, below 2^131 + small
   logic [AccWidth:0]   acc_ff, acc_in;
   logic [AccWidth+1:0] h_ff, h_in;
   // product accumulator: h * r fits in 2^(132+124)
   logic [259:0]        prod_ff, prod_in;
   logic [AccWidth:0]   red_ff, red_in;
   rsp_payload_type     tag_ff, tag_in;

   logic [127:0]        r_clamped;
   logic [128:0]        blk_padded;
   logic [4:0]          nbytes;
   logic [127:0]        byte_mask;
   logic [31:0]         h_word;
   logic [31:0]         r_word;
   logic [2:0]          pos;
   logic [63:0]         partial;
   logic [AccWidth+5:0] fold;
   logic [AccWidth+1:0] fold2;
   logic [AccWidth+2:0] minus_p;

   assign r_clamped = key_r & R_CLAMP_MASK;
   assign nbytes = (req_data.block_bytes > 5'd16) ? 5'd16 : req_data.block_bytes;

   always_comb begin
      byte_mask = '0;
      blk_padded = '0;
      for (int i = 0; i < 16; i++) begin
         if (5'(i) < nbytes) byte_mask[i*8 +: 8] = 8'hFF;
      end
      blk_padded[127:0] = {req_data.block_high, req_data.block_low} & byte_mask;
      blk_padded[{nbytes, 3'b000}] = 1'b1;
   end

   // 32-bit word of h times 32-bit word of r, one pair per step
   always_comb begin
      h_word = '0;
      case (cmd.limb)
         3'd0: h_word = h_ff[31:0];
         3'd1: h_word = h_ff[63:32];
         3'd2: h_word = h_ff[95:64];
         3'd3: h_word = h_ff[127:96];
         3'd4: h_word = {28'd0, h_ff[131:128]};
         default: h_word = '0;
      endcase
      r_word = r_clamped[{cmd.rword, 5'b00000} +: 32];
      pos = cmd.limb + 3'(cmd.rword);
   end

   always_comb begin
      partial = 64'(h_word) * 64'(r_word);
      fold = 136'(prod_ff[AccWidth-1:0]) + 136'(prod_ff[259:AccWidth]) * 136'd5;
      fold2 = 132'(red_ff[AccWidth-1:0]) + 132'(red_ff[AccWidth]) * 132'd5;
      minus_p = 133'(fold2) + 133'd5;
   end

   always_comb begin
      acc_in  = acc_ff;
      h_in    = h_ff;
      prod_in = prod_ff;
      red_in  = red_ff;
      tag_in  = tag_ff;
      if (cmd.load) begin
         h_in = 132'(acc_ff) + 132'(blk_padded);
      end
      if (cmd.clear_prod) begin
         prod_in = '0;
      end else if (cmd.mac) begin
         prod_in = prod_ff + (260'(partial) << {pos, 5'b00000});
      end
      if (cmd.reduce) begin
         // fold < 2^131 after this; one more fold below
         red_in = 131'(fold[AccWidth+5:AccWidth] * 136'd5 + 136'(fold[AccWidth-1:0]));
      end
      if (cmd.finish) begin
         // red is now below 2^130 + 2^5; fold top bit once more then subtract p
         if (minus_p[AccWidth+2:AccWidth] != 3'd0)
            acc_in = 131'(minus_p) & {1'b0, {AccWidth{1'b1}}};
         else
            acc_in = 131'(fold2);
      end
      if (cmd.tag) begin
         tag_in = {acc_ff[127:0] + key_s};
         acc_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
      end else begin
         acc_ff <= acc_in;
      end
      h_ff    <= h_in;
      prod_ff <= prod_in;
      red_ff  <= red_in;
      tag_ff  <= tag_in;
   end

   assign tag_out = tag_ff;

endmodule
`default_nettype wire

[hdl/p1305_control.sv]
`timescale 1ns / 1ps
`default_nettype none
module p1305_control
   import p1305_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [4:0] req_bytes,
   input  wire logic       req_last,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output dp_cmd_type      cmd
);

   typedef enum logic [2:0] {
      S_IDLE, S_MAC, S_REDUCE, S_FINISH, S_TAG, S_OUT
   } state_type;

   state_type  state_ff;
   logic [2:0] limb_ff;
   logic [1:0] rword_ff;
   logic       last_ff;
   logic       rsp_valid_ff;

   assign req_ready = (state_ff == S_IDLE) && !rsp_valid_ff;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd = '0;
      cmd.limb = limb_ff;
      cmd.rword = rword_ff;
      case (state_ff)
         S_IDLE:   begin
            cmd.load = req_valid && req_ready;
            cmd.clear_prod = 1'b1;
         end
         S_MAC:    cmd.mac = 1'b1;
         S_REDUCE: cmd.reduce = 1'b1;
         S_FINISH: cmd.finish = 1'b1;
         S_TAG:    cmd.tag = 1'b1;
         default:  cmd = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         limb_ff <= '0;
         rword_ff <= '0;
         last_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_ready) rsp_valid_ff <= 1'b0;
         case (state_ff)
            S_IDLE: begin
               limb_ff <= '0;
               rword_ff <= '0;
               if (req_valid && req_ready) begin
                  last_ff <= req_last;
                  if (req_bytes != 5'd0) state_ff <= S_MAC;
                  else if (req_last) state_ff <= S_TAG;
               end
            end
            S_MAC: begin
               rword_ff <= rword_ff + 2'd1;
               if (rword_ff == 2'd3) begin
                  limb_ff <= limb_ff + 3'd1;
                  if (limb_ff == 3'd4) state_ff <= S_REDUCE;
               end
            end
            S_REDUCE: state_ff <= S_FINISH;
            S_FINISH: state_ff <= last_ff ? S_TAG : S_IDLE;
            S_TAG: state_ff <= S_OUT;
            S_OUT: begin
               rsp_valid_ff <= 1'b1;
               state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

endmodule
`default_nettype wire

[hdl/poly1305_mac_accumulator_unit.sv]
// Poly1305 tag engine. Load r and s through the csr port while idle, then send
// 16-byte blocks; the tag comes out after the block marked last. A block passes
// through twenty 32x32 partial products on one multiplier, a reduction, a final
// subtraction and a return to idle; a last block then goes through the tag and
// output states, and a last block with no bytes goes from idle straight to the
// tag state. A new block is taken once the previous tag has been transferred.
`timescale 1ns / 1ps
`default_nettype none
`include "poly1305_mac_accumulator_unit_macros.svh"
module poly1305_mac_accumulator_unit
   import p1305_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire req_payload_type        req_data,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output rsp_payload_type             rsp_data,
   input  wire logic                   csr_write,
   input  wire logic [CsrIdxWidth-1:0] csr_index,
   input  wire logic [63:0]            csr_data
);

   logic [63:0] r_low_ff, r_high_ff, s_low_ff, s_high_ff;
   dp_cmd_type  cmd;

   always_ff @(posedge clock) begin
      if (reset) begin
         r_low_ff <= '0;
         r_high_ff <= '0;
         s_low_ff <= '0;
         s_high_ff <= '0;
      end else if (csr_write) begin
         case (csr_index)
            CSR_R_LOW:  r_low_ff <= csr_data;
            CSR_R_HIGH: r_high_ff <= csr_data;
            CSR_S_LOW:  s_low_ff <= csr_data;
            CSR_S_HIGH: s_high_ff <= csr_data;
            default:    r_low_ff <= r_low_ff;
         endcase
      end
   end

   p1305_control u_control (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_bytes (req_data.block_bytes),
      .req_last  (req_data.last_block),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd)
   );

   p1305_datapath u_datapath (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .req_data (req_data),
      .key_r    ({r_high_ff, r_low_ff}),
      .key_s    ({s_high_ff, s_low_ff}),
      .tag_out  (rsp_data)
   );

   `P1305_ASSERT(a_no_accept_while_rsp, rsp_valid |-> !req_ready, "input taken while tag pending")
   `P1305_ASSERT(a_rsp_held, rsp_valid && !rsp_ready |=> $stable(rsp_data), "tag moved in stall")
   `P1305_ASSERT_RST(a_reset_quiet, reset |=> !rsp_valid, "tag valid after reset")

endmodule
`default_nettype wire
